// File: sv/bmp_pkg.sv
`timescale 1ns / 1ps

package bmp_pkg;

  localparam int CH_W          = 8;
  localparam int DIM_W         = 13;
  localparam int CNT_W         = 12;
  localparam int COORD_W       = 9;
  localparam int COUNTER_LIMIT = 4096;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(COUNTER_LIMIT);

  typedef struct packed {
    logic [CH_W-1:0] ch2;
    logic [CH_W-1:0] ch1;
    logic [CH_W-1:0] ch0;
  } pix_t;

  function automatic pix_t chan_max(input pix_t a, input pix_t b);
    pix_t r;
    r.ch0 = (a.ch0 > b.ch0) ? a.ch0 : b.ch0;
    r.ch1 = (a.ch1 > b.ch1) ? a.ch1 : b.ch1;
    r.ch2 = (a.ch2 > b.ch2) ? a.ch2 : b.ch2;
    return r;
  endfunction

endpackage

// File: sv/block_max_pooling.sv
`timescale 1ns / 1ps

// Max pooling over non-overlapping BLOCK_SIZE x BLOCK_SIZE tiles of a raster stream
// of three-channel 8-bit pixels.
// The in_ channel takes one pixel per request in raster order; the cfg_ port sets
// the image width and height, and the user must write it only while the block is
// idle, which the block itself does not enforce. For each tile the out_ channel
// delivers one request with the three channel maxima and the tile coordinates;
// out_tlast marks the last tile of the frame. Partial tiles at the right and bottom
// edges pool only the pixels that exist. One pixel is accepted in every cycle unless
// a tile end stalls on the output. A tile's result is registered in the input stage,
// then in the output register. The partial maxima of the tile row live in a memory
// with one entry per tile column, read into a register when a pixel is accepted.
// Reset clears the column and row counters and empties the pipeline; the memory
// is not cleared, because the first row of each tile row never uses what it reads.
// When the receiver stalls, the output register holds its result and the block
// keeps accepting pixels that complete no tile; a tile's last pixel stalls in_tready.

module block_max_pooling #(
  parameter int BLOCK_SIZE = 8,
  parameter int MAX_WIDTH  = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // pixel_ch0, pixel_ch1, pixel_ch2
  input  logic [23:0]                    in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // max_ch0, max_ch1, max_ch2, block_col, block_row, zero fill
  output logic [47:0]                    out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bmp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bmp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bmp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int STORE_DEPTH = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int RX_W        = $clog2(BLOCK_SIZE);
  localparam int BROW_W      = $clog2((bmp_pkg::COUNTER_LIMIT - 1) / BLOCK_SIZE + 1);
  localparam int WIDTH_LIM   = (MAX_WIDTH < bmp_pkg::COUNTER_LIMIT) ?
                               MAX_WIDTH : bmp_pkg::COUNTER_LIMIT;
  localparam int DW = bmp_pkg::DIM_W;
  localparam int CW = bmp_pkg::CNT_W;

  localparam logic [RX_W-1:0] RX_LAST = RX_W'(BLOCK_SIZE - 1);

  // Configuration registers.
  logic [DW-1:0] width_r, height_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bmp_pkg::DIM_RESET;
      height_r <= bmp_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        bmp_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[DW-1:0];
        bmp_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      bmp_pkg::REG_IMAGE_WIDTH:  cfg_prdata = bmp_pkg::CFG_DATA_W'(width_r);
      bmp_pkg::REG_IMAGE_HEIGHT: cfg_prdata = bmp_pkg::CFG_DATA_W'(height_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  logic [DW-1:0] eff_w, eff_h;

  always_comb begin
    if (width_r == '0)                eff_w = DW'(1);
    else if (width_r > DW'(WIDTH_LIM)) eff_w = DW'(WIDTH_LIM);
    else                              eff_w = width_r;
    if (height_r == '0)                             eff_h = DW'(1);
    else if (height_r > DW'(bmp_pkg::COUNTER_LIMIT)) eff_h = DW'(bmp_pkg::COUNTER_LIMIT);
    else                                            eff_h = height_r;
  end

  // Raster counters.
  logic [CW-1:0]     col_r, row_r;
  logic [RX_W-1:0]   rx_r, ry_r;
  logic [IDX_W-1:0]  bc_r;
  logic [BROW_W-1:0] brow_r;
  logic              last_col, last_row, accept;

  assign accept   = in_tvalid && in_tready;
  assign last_col = ({1'b0, col_r} + DW'(1)) >= eff_w;
  assign last_row = ({1'b0, row_r} + DW'(1)) >= eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      rx_r   <= '0;
      ry_r   <= '0;
      bc_r   <= '0;
      brow_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_r <= '0;
        rx_r  <= '0;
        bc_r  <= '0;
        if (last_row) begin
          row_r  <= '0;
          ry_r   <= '0;
          brow_r <= '0;
        end else begin
          row_r <= row_r + CW'(1);
          if (ry_r == RX_LAST) begin
            ry_r   <= '0;
            brow_r <= brow_r + BROW_W'(1);
          end else begin
            ry_r <= ry_r + RX_W'(1);
          end
        end
      end else begin
        col_r <= col_r + CW'(1);
        if (rx_r == RX_LAST) begin
          rx_r <= '0;
          bc_r <= bc_r + IDX_W'(1);
        end else begin
          rx_r <= rx_r + RX_W'(1);
        end
      end
    end
  end

  // Input stage.
  logic              s1_valid_r;
  bmp_pkg::pix_t     s1_pix_r;
  logic              s1_rx0_r, s1_ry0_r, s1_blk_end_r, s1_emit_r, s1_done_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [BROW_W-1:0] s1_brow_r;
  logic              s1_adv, blk_end, wr_en;

  assign blk_end = (rx_r == RX_LAST) || last_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r     <= bmp_pkg::pix_t'(in_tdata);
      s1_rx0_r     <= (rx_r == '0);
      s1_ry0_r     <= (ry_r == '0);
      s1_blk_end_r <= blk_end;
      s1_emit_r    <= blk_end && ((ry_r == RX_LAST) || last_row);
      s1_done_r    <= last_col && last_row;
      s1_idx_r     <= bc_r;
      s1_brow_r    <= brow_r;
    end
  end

  // Column store with write-to-read forwarding.
  bmp_pkg::pix_t store_mem [STORE_DEPTH];
  bmp_pkg::pix_t rd_r, fwd_data_r;
  logic          fwd_r;
  bmp_pkg::pix_t cbm_r, cbm_nxt, stored, merged;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= store_mem[bc_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[s1_idx_r] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (accept) begin
      fwd_r <= wr_en && (s1_idx_r == bc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data_r <= merged;
    end
  end

  always_comb begin
    cbm_nxt = s1_rx0_r ? s1_pix_r : bmp_pkg::chan_max(cbm_r, s1_pix_r);
    stored  = fwd_r ? fwd_data_r : rd_r;
    merged  = s1_ry0_r ? cbm_nxt : bmp_pkg::chan_max(cbm_nxt, stored);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cbm_r <= '0;
    end else if (s1_adv) begin
      cbm_r <= cbm_nxt;
    end
  end

  // Output register.
  logic          out_valid_r, out_last_r;
  bmp_pkg::pix_t out_max_r;
  logic [bmp_pkg::COORD_W-1:0] out_col_r, out_row_r;
  logic [31:0]   bc_ext, brow_ext;

  assign s1_adv    = s1_valid_r && (!s1_emit_r || !out_valid_r || out_tready);
  assign wr_en     = s1_adv && s1_blk_end_r;
  assign in_tready = !s1_valid_r || s1_adv;
  assign bc_ext    = 32'(s1_idx_r);
  assign brow_ext  = 32'(s1_brow_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_max_r  <= merged;
      out_col_r  <= bc_ext[bmp_pkg::COORD_W-1:0];
      out_row_r  <= brow_ext[bmp_pkg::COORD_W-1:0];
      out_last_r <= s1_done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'b0, out_row_r, out_col_r,
                       out_max_r.ch2, out_max_r.ch1, out_max_r.ch0};

endmodule
